// ----- rtl/hdff_pkg.sv -----
// Shared constants and types for the hashed duplicate flag filter.
package hdff_pkg;

  localparam int unsigned HashW        = 32;
  localparam int unsigned SlotIdxW     = 8;
  localparam int unsigned TableSlotsDef = 256;

  localparam logic [HashW-1:0] FnvBasis = 32'h811C_9DC5;
  localparam logic [HashW-1:0] FnvPrime = 32'h0100_0193;
  localparam logic [HashW-1:0] MixConst = 32'h9E37_79B9;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_key;
    logic       last_of_string;
    logic       string_empty;
  } hdff_item_t;

  typedef struct packed {
    logic             valid;
    logic [HashW-1:0] hash;
  } hdff_key_t;

endpackage

// ----- rtl/hdff_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hdff_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/hdff_hash.sv -----
// Per-byte FNV-1a hashing of category and key strings and the hash combine.
module hdff_hash import hdff_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  hdff_item_t item_i,
  output hdff_key_t  key_o
);

  logic             v1_q;
  hdff_item_t       item_q;
  logic [HashW-1:0] rh_q, rh_d;
  logic [HashW-1:0] cat_q, cat_d;
  logic [HashW-1:0] folded;
  logic [HashW-1:0] mixed;
  logic             v2_q;
  logic [HashW-1:0] done2_q;
  logic [HashW-1:0] cat2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      rh_q  <= FnvBasis;
      cat_q <= '0;
    end else begin
      v1_q  <= valid_i;
      v2_q  <= v1_q && item_q.last_of_string && item_q.is_key;
      rh_q  <= rh_d;
      cat_q <= cat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_i;
    done2_q <= folded;
    cat2_q  <= cat_q;
  end

  always_comb begin
    folded = item_q.string_empty ? rh_q
                                 : HashW'((rh_q ^ {24'b0, item_q.data_byte}) * FnvPrime);
    rh_d  = rh_q;
    cat_d = cat_q;
    if (v1_q) begin
      if (item_q.last_of_string) begin
        rh_d = FnvBasis;
        if (!item_q.is_key) begin
          cat_d = folded;
        end
      end else begin
        rh_d = folded;
      end
    end
  end

  assign mixed = done2_q + MixConst + (cat2_q << 6) + (cat2_q >> 2);

  assign key_o.valid = v2_q;
  assign key_o.hash  = cat2_q ^ mixed;

endmodule

// ----- rtl/hdff_slot.sv -----
// Pipelined reduction of the combined hash modulo the table size.
module hdff_slot import hdff_pkg::*; #(
  parameter int unsigned TableSlots = TableSlotsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hdff_key_t                     key_i,
  output hdff_key_t                     key_o,
  output logic [$clog2(TableSlots)-1:0] slot_o
);

  localparam int unsigned SlotW = $clog2(TableSlots);
  localparam int unsigned XW    = 29;
  localparam int unsigned MW    = XW + 2;
  localparam int unsigned Fold  = 65536 % TableSlots;
  localparam int unsigned Shift = XW + SlotW;
  localparam longint unsigned Recip =
    ((64'd1 << Shift) + longint'(TableSlots) - 64'd1) / longint'(TableSlots);

  hdff_key_t        a_q, b_q, c_q;
  logic [XW-1:0]    hi_ext, lo_ext, xa;
  logic [XW-1:0]    xb_q, xc_q;
  logic [XW+MW-1:0] prod_b;
  logic [XW-1:0]    qc_q;
  logic [XW-1:0]    qn;
  logic [XW-1:0]    rem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '0;
      c_q <= '0;
    end else begin
      a_q <= key_i;
      b_q <= a_q;
      c_q <= b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    xb_q <= xa;
    xc_q <= xb_q;
    qc_q <= XW'(prod_b >> Shift);
  end

  assign hi_ext = XW'(a_q.hash[31:16]);
  assign lo_ext = XW'(a_q.hash[15:0]);
  assign xa     = hi_ext * XW'(Fold) + lo_ext;
  assign prod_b = xb_q * MW'(Recip);
  assign qn     = qc_q * XW'(TableSlots);
  assign rem    = xc_q - qn;

  assign key_o  = c_q;
  assign slot_o = SlotW'(rem);

endmodule

// ----- rtl/hdff_table.sv -----
// Seen-hash table lookup and update, with reset clearing sweep and result register.
module hdff_table import hdff_pkg::*; #(
  parameter int unsigned TableSlots = TableSlotsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hdff_key_t                     key_i,
  input  logic [$clog2(TableSlots)-1:0] slot_i,
  output logic                          clearing_o,
  output logic                          result_valid_o,
  output logic                          emit_o,
  output logic [SlotIdxW-1:0]           slot_index_o,
  output logic [HashW-1:0]              combined_hash_o
);

  localparam int unsigned SlotW = $clog2(TableSlots);

  logic             clr_q, clr_d;
  logic [SlotW-1:0] clr_cnt_q, clr_cnt_d;
  logic             vd_q;
  logic [HashW-1:0] hd_q;
  logic [SlotW-1:0] sd_q;
  logic             fwd_v_q;
  logic [SlotW-1:0] fwd_slot_q;
  logic [HashW-1:0] fwd_data_q;
  logic [HashW-1:0] rdata;
  logic [HashW-1:0] prev;
  logic             upd;
  logic             we;
  logic [SlotW-1:0] waddr;
  logic [HashW-1:0] wdata;
  logic             res_v_q;
  logic             emit_q;
  logic [SlotW-1:0] res_slot_q;
  logic [HashW-1:0] res_hash_q;

  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      if (clr_cnt_q == SlotW'(TableSlots - 1)) begin
        clr_d = 1'b0;
      end else begin
        clr_cnt_d = clr_cnt_q + 1'b1;
      end
    end
  end

  always_comb begin
    prev = (fwd_v_q && fwd_slot_q == sd_q) ? fwd_data_q : rdata;
    upd  = vd_q && (prev == '0);
  end

  always_comb begin
    if (clr_q) begin
      we    = 1'b1;
      waddr = clr_cnt_q;
      wdata = '0;
    end else begin
      we    = upd;
      waddr = sd_q;
      wdata = hd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      vd_q      <= 1'b0;
      fwd_v_q   <= 1'b0;
      res_v_q   <= 1'b0;
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
      vd_q      <= key_i.valid;
      fwd_v_q   <= upd;
      res_v_q   <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hd_q       <= key_i.hash;
    sd_q       <= slot_i;
    fwd_slot_q <= sd_q;
    fwd_data_q <= hd_q;
    emit_q     <= prev != hd_q;
    res_slot_q <= sd_q;
    res_hash_q <= hd_q;
  end

  hdff_ram #(
    .Width(HashW),
    .Depth(TableSlots)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(slot_i),
    .rdata_o(rdata)
  );

  assign clearing_o      = clr_q;
  assign result_valid_o  = res_v_q;
  assign emit_o          = emit_q;
  assign slot_index_o    = SlotIdxW'(res_slot_q);
  assign combined_hash_o = res_hash_q;

endmodule

// ----- rtl/hashed_duplicate_flag_filter.sv -----
// Top level of the hashed duplicate flag filter.
//
// A request carries one byte of a category or key string and is taken at a
// rising edge where start is high and busy is low. Bytes fold into an FNV-1a
// hash; a category end records the category hash, and a key end combines it
// with the key hash and looks the result up in a table of TableSlots entries.
// Only a key end produces a result: result_valid_o is high for exactly one
// cycle with emit_o, slot_index_o and combined_hash_o. The receiver cannot
// stall, so results are never held. While busy is low, one request is taken
// every cycle; the hash register updates once per byte and the table read,
// compare and write are pipelined with write forwarding, so back-to-back key
// ends on the same slot are handled without gaps.
// After reset the block sweeps the table to zero, one slot per cycle, and
// holds busy high until the last slot is cleared; no request is taken in the sweep.
// The slot is the combined hash modulo TableSlots, reduced in three stages.
module hashed_duplicate_flag_filter import hdff_pkg::*; #(
  parameter int unsigned TableSlots = TableSlotsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [7:0]          data_byte_i,
  input  logic                is_key_i,
  input  logic                last_of_string_i,
  input  logic                string_empty_i,
  output logic                result_valid_o,
  output logic                emit_o,
  output logic [SlotIdxW-1:0] slot_index_o,
  output logic [HashW-1:0]    combined_hash_o
);

  hdff_item_t                    item;
  hdff_key_t                     hash_key;
  hdff_key_t                     slot_key;
  logic [$clog2(TableSlots)-1:0] slot;
  logic                          clearing;

  assign item.data_byte      = data_byte_i;
  assign item.is_key         = is_key_i;
  assign item.last_of_string = last_of_string_i;
  assign item.string_empty   = string_empty_i;

  hdff_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(start && !clearing),
    .item_i (item),
    .key_o  (hash_key)
  );

  hdff_slot #(
    .TableSlots(TableSlots)
  ) u_slot (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .key_i (hash_key),
    .key_o (slot_key),
    .slot_o(slot)
  );

  hdff_table #(
    .TableSlots(TableSlots)
  ) u_table (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .key_i          (slot_key),
    .slot_i         (slot),
    .clearing_o     (clearing),
    .result_valid_o (result_valid_o),
    .emit_o         (emit_o),
    .slot_index_o   (slot_index_o),
    .combined_hash_o(combined_hash_o)
  );

  assign busy = clearing;

  // No result can appear while the table is still being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy |-> !result_valid_o)
    else $error("result during table clear");

  // The clearing sweep does not end before it has covered the full table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $fell(busy) |-> $past(busy, TableSlots))
    else $error("table clear ended early");

  // A key end only reaches the table stage after the sweep is over.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   slot_key.valid |-> !clearing)
    else $error("lookup issued during table clear");

endmodule
